// ===== src/rpi_pkg.sv =====
package rpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W;
    localparam int QUO_W     = WORD_W - 1;
    localparam int DIV_W     = MAG_W + QUO_W + FRAC_BITS;
    localparam int PT_W      = PROD_W + 1;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] ox;
        logic signed [WORD_W-1:0] oy;
        logic signed [WORD_W-1:0] oz;
        logic signed [WORD_W-1:0] dx;
        logic signed [WORD_W-1:0] dy;
        logic signed [WORD_W-1:0] dz;
    } side_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [DIV_W-1:0] num;
        logic [MAG_W-1:0] den;
    } div_in_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [QUO_W-1:0] t;
    } div_out_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PT_W-1:0] s);
        logic signed [PT_W-1:0] hi_lim;
        logic signed [PT_W-1:0] lo_lim;
        logic signed [WORD_W-1:0] r;
        hi_lim = PT_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo_lim = -hi_lim - PT_W'(1);
        if (s > hi_lim)
        begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (s < lo_lim)
        begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            r = s[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/ray_plane_intersect_top.sv =====
// Throughput: one word per cycle; busy is always low and start may stay high.
// The 31-step restoring divider for t is the longest part of the pipeline.
// Results are not held: each is valid on the done strobe for one cycle only.
// Asynchronous active-low reset clears every valid bit; no word is in flight after it.
module ray_plane_intersect_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] plane_offset,
    output logic                              done,
    output logic                              hit,
    output logic signed [rpi_pkg::WORD_W-1:0] point_x,
    output logic signed [rpi_pkg::WORD_W-1:0] point_y,
    output logic signed [rpi_pkg::WORD_W-1:0] point_z
);
    import rpi_pkg::*;

    div_in_t  div_in;
    div_out_t div_out;

    assign busy = 1'b0;

    rpi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .div_in       (div_in)
    );

    rpi_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_in  (div_in),
        .div_out (div_out)
    );

    rpi_point u_point (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_out (div_out),
        .done    (done),
        .hit     (hit),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z)
    );

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (point_x == '0 && point_y == '0 && point_z == '0))
        else $error("miss word carries a nonzero point");
    a_div_feeds_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.valid |-> ##2 done)
        else $error("divider word lost before output");
    a_hit_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_out.valid && !div_out.side.hit) |-> ##2 !hit)
        else $error("miss flag changed in point stages");
`endif

endmodule

// ===== src/rpi_front.sv =====
module rpi_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] plane_offset,
    output rpi_pkg::div_in_t                 div_in
);
    import rpi_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    side_t                    side1_reg, side2_reg;
    div_in_t                  out_reg;
    logic signed [PROD_W-1:0] pdx_reg, pdy_reg, pdz_reg, pox_reg, poy_reg, poz_reg;
    logic signed [PROD_W-1:0] pdx_next, pdy_next, pdz_next, pox_next, poy_next, poz_next;
    logic signed [WORD_W-1:0] d_reg;
    logic signed [SUM_W-1:0]  den_reg, num_reg, den_next, num_next;
    logic                     miss;
    logic [MAG_W-1:0]         dmag, nmag;
    div_in_t                  out_next;

    assign pdx_next = dir_x * normal_x;
    assign pdy_next = dir_y * normal_y;
    assign pdz_next = dir_z * normal_z;
    assign pox_next = origin_x * normal_x;
    assign poy_next = origin_y * normal_y;
    assign poz_next = origin_z * normal_z;

    assign den_next = SUM_W'(pdx_reg) + SUM_W'(pdy_reg) + SUM_W'(pdz_reg);
    assign num_next = -(SUM_W'(pox_reg) + SUM_W'(poy_reg) + SUM_W'(poz_reg)
                      + (SUM_W'(d_reg) <<< FRAC_BITS));

    always_comb
    begin
        miss = (den_reg == '0) ||
               ((num_reg != '0) && (num_reg[SUM_W-1] != den_reg[SUM_W-1]));
        dmag = den_reg[SUM_W-1] ? MAG_W'(-den_reg) : MAG_W'(den_reg);
        nmag = num_reg[SUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
        out_next.valid    = v2_reg;
        out_next.side     = side2_reg;
        out_next.side.hit = ~miss;
        out_next.num      = DIV_W'(nmag) << FRAC_BITS;
        out_next.den      = dmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pdx_reg <= pdx_next;
        pdy_reg <= pdy_next;
        pdz_reg <= pdz_next;
        pox_reg <= pox_next;
        poy_reg <= poy_next;
        poz_reg <= poz_next;
        d_reg   <= plane_offset;
        side1_reg <= '{hit: 1'b0, ox: origin_x, oy: origin_y, oz: origin_z,
                       dx: dir_x, dy: dir_y, dz: dir_z};
        den_reg   <= den_next;
        num_reg   <= num_next;
        side2_reg <= side1_reg;
        out_reg   <= out_next;
    end

    always_comb
    begin
        div_in       = out_reg;
        div_in.valid = v3_reg;
    end

endmodule

// ===== src/rpi_div.sv =====
module rpi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rpi_pkg::div_in_t  div_in,
    output rpi_pkg::div_out_t div_out
);
    import rpi_pkg::*;

    logic [DIV_W-1:0] r_reg   [0:QUO_W];
    logic [MAG_W-1:0] d_reg   [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             sat_reg [0:QUO_W];
    side_t            side_reg[0:QUO_W];
    logic             v_reg   [0:QUO_W];
    logic             ovf;

    assign ovf = div_in.num >= (DIV_W'(div_in.den) << QUO_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= div_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= div_in.num;
        d_reg[0]    <= div_in.den;
        q_reg[0]    <= '0;
        sat_reg[0]  <= ovf;
        side_reg[0] <= div_in.side;
    end

    for (genvar i = 1; i <= QUO_W; i++)
    begin : g_step
        logic [DIV_W-1:0] shd;
        logic             ge;

        assign shd = DIV_W'(d_reg[i-1]) << (QUO_W - i);
        assign ge  = r_reg[i-1] >= shd;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[i]    <= ge ? (r_reg[i-1] - shd) : r_reg[i-1];
            q_reg[i]    <= {q_reg[i-1][QUO_W-2:0], ge};
            d_reg[i]    <= d_reg[i-1];
            sat_reg[i]  <= sat_reg[i-1];
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign div_out.valid = v_reg[QUO_W];
    assign div_out.side  = side_reg[QUO_W];
    assign div_out.t     = sat_reg[QUO_W] ? {QUO_W{1'b1}} : q_reg[QUO_W];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[QUO_W] && side_reg[QUO_W].hit && !sat_reg[QUO_W])
            |-> (r_reg[QUO_W] < DIV_W'(d_reg[QUO_W])))
        else $error("division remainder not below divisor");
`endif

endmodule

// ===== src/rpi_point.sv =====
module rpi_point (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpi_pkg::div_out_t                 div_out,
    output logic                              done,
    output logic                              hit,
    output logic signed [rpi_pkg::WORD_W-1:0] point_x,
    output logic signed [rpi_pkg::WORD_W-1:0] point_y,
    output logic signed [rpi_pkg::WORD_W-1:0] point_z
);
    import rpi_pkg::*;

    logic                     v1_reg, done_reg;
    side_t                    side1_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [WORD_W-1:0] ts;
    logic                     hit_reg;
    logic signed [WORD_W-1:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;

    assign ts = $signed({1'b0, div_out.t});

    always_comb
    begin
        x_next = '0;
        y_next = '0;
        z_next = '0;
        if (side1_reg.hit)
        begin
            x_next = sat_word(PT_W'(side1_reg.ox) + PT_W'(px_reg >>> FRAC_BITS));
            y_next = sat_word(PT_W'(side1_reg.oy) + PT_W'(py_reg >>> FRAC_BITS));
            z_next = sat_word(PT_W'(side1_reg.oz) + PT_W'(pz_reg >>> FRAC_BITS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= div_out.valid;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= div_out.side;
        px_reg    <= ts * div_out.side.dx;
        py_reg    <= ts * div_out.side.dy;
        pz_reg    <= ts * div_out.side.dz;
        hit_reg   <= side1_reg.hit;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign point_x = x_reg;
    assign point_y = y_reg;
    assign point_z = z_reg;

endmodule

// ===== sim/intersect_checker.sv =====
module intersect_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] origin_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] dir_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] normal_z,
    input  logic signed [rpi_pkg::WORD_W-1:0] plane_offset,
    input  logic                              done,
    input  logic                              hit,
    input  logic signed [rpi_pkg::WORD_W-1:0] point_x,
    input  logic signed [rpi_pkg::WORD_W-1:0] point_y,
    input  logic signed [rpi_pkg::WORD_W-1:0] point_z,
    output int                                pending,
    output int                                fail_count
);
    import rpi_pkg::*;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic  hit;
        word_t px;
        word_t py;
        word_t pz;
    } intersection_t;

    intersection_t expected_points[$];

    function automatic wide_t widen(input word_t v);
        return wide_t'(v);
    endfunction

    function automatic word_t clamp_word(input wide_t s);
        word_t r;
        if (s > widen(32'sh7FFFFFFF))
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (s < widen(32'sh80000000))
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = s[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic word_t hit_coord(input word_t o, input word_t d, input logic [127:0] t);
        wide_t prod;
        prod = widen(d) * $signed(t);
        return clamp_word((prod >>> FRAC_BITS) + widen(o));
    endfunction

    function automatic intersection_t intersect_ray(
        input word_t ox, input word_t oy, input word_t oz,
        input word_t dx, input word_t dy, input word_t dz,
        input word_t nx, input word_t ny, input word_t nz, input word_t pd);
        intersection_t r;
        wide_t den;
        wide_t num;
        logic [127:0] den_mag;
        logic [127:0] num_mag;
        logic [127:0] t;
        r = '0;
        den = widen(dx) * widen(nx) + widen(dy) * widen(ny) + widen(dz) * widen(nz);
        num = -(widen(ox) * widen(nx) + widen(oy) * widen(ny) + widen(oz) * widen(nz)
                + (widen(pd) <<< FRAC_BITS));
        if (den == 0)
        begin
            return r;
        end
        if (num != 0 && (num < 0) != (den < 0))
        begin
            return r;
        end
        den_mag = (den < 0) ? -den : den;
        num_mag = (num < 0) ? -num : num;
        t = (num_mag << FRAC_BITS) / den_mag;
        if (t > 128'h7FFFFFFF)
        begin
            t = 128'h7FFFFFFF;
        end
        r.hit = 1'b1;
        r.px = hit_coord(ox, dx, t);
        r.py = hit_coord(oy, dy, t);
        r.pz = hit_coord(oz, dz, t);
        return r;
    endfunction

    assign pending = expected_points.size();

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        intersection_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result word hit=%0b x=%0d y=%0d z=%0d",
                             $time, hit, point_x, point_y, point_z);
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                        fail_count++;
                    end
                    if (point_x !== want.px)
                    begin
                        $display("%0t: point_x expected %0d actual %0d", $time, want.px, point_x);
                        fail_count++;
                    end
                    if (point_y !== want.py)
                    begin
                        $display("%0t: point_y expected %0d actual %0d", $time, want.py, point_y);
                        fail_count++;
                    end
                    if (point_z !== want.pz)
                    begin
                        $display("%0t: point_z expected %0d actual %0d", $time, want.pz, point_z);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_points.push_back(intersect_ray(origin_x, origin_y, origin_z,
                                                        dir_x, dir_y, dir_z,
                                                        normal_x, normal_y, normal_z,
                                                        plane_offset));
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import rpi_pkg::*;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t ONE  = 32'sh00010000;
    localparam word_t WMAX = 32'sh7FFFFFFF;
    localparam word_t WMIN = 32'sh80000000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t origin_x, origin_y, origin_z;
    word_t dir_x, dir_y, dir_z;
    word_t normal_x, normal_y, normal_z;
    word_t plane_offset;
    logic  done;
    logic  hit;
    word_t point_x, point_y, point_z;
    int    pending;
    int    fail_count;
    int    random_left;

    ray_plane_intersect_top DUT (.*);

    intersect_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_ray(input word_t ox, input word_t oy, input word_t oz,
                            input word_t dx, input word_t dy, input word_t dz,
                            input word_t nx, input word_t ny, input word_t nz,
                            input word_t pd);
        origin_x = ox; origin_y = oy; origin_z = oz;
        dir_x = dx; dir_y = dy; dir_z = dz;
        normal_x = nx; normal_y = ny; normal_z = nz;
        plane_offset = pd;
        start = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    function automatic word_t any_word();
        return word_t'($urandom());
    endfunction

    function automatic word_t near_word();
        return word_t'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
    endfunction

    task automatic send_random_ray();
        int kind;
        word_t n;
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            send_ray(any_word(), any_word(), any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word(), any_word());
        end
        else if (kind < 9)
        begin
            n = near_word();
            send_ray(near_word(), near_word(), near_word(), near_word(), near_word(), n,
                     near_word() >>> $urandom_range(0, 12), near_word() >>> $urandom_range(0, 12),
                     n, near_word());
        end
        else
        begin
            send_ray(any_word(), any_word(), any_word(), near_word(), near_word(), 32'sd0,
                     32'sd0, 32'sd0, near_word(), any_word());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
        {normal_x, normal_y, normal_z, plane_offset} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_ray(0, 0, ONE, 0, 0, -ONE, 0, 0, ONE, 0);
        send_ray(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0);
        send_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0, 0);
        send_ray(ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 5);
        send_ray(0, 0, 1, 0, 0, WMAX, 0, 0, WMAX, 0);
        send_ray(0, 0, -1, 0, 0, WMAX, 0, 0, WMAX, 0);
        send_ray(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 1, 0, 0, WMIN);
        send_ray(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 1, 0, 0, WMAX);
        send_ray(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        send_ray(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_ray(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN);
        send_ray(0, 0, 0, 1, 1, 1, 1, 0, 0, WMIN);
        send_ray(0, 0, 0, -1, -1, -1, 1, 0, 0, WMAX);
        send_ray(ONE, -ONE, 3 * ONE, ONE, 2 * ONE, -ONE, 0, ONE, 0, -7 * ONE);
        send_ray(-5, 7, 9, 1, -1, 1, ONE, ONE, ONE, -ONE);
        send_ray(0, 0, 0, ONE, -ONE, 0, ONE, ONE, 0, WMAX);
        send_ray(123, 0, 0, 3, 0, 0, ONE, 0, 0, -1);

        random_left = 1100;
        while (random_left > 0)
        begin
            send_random_ray();
            maybe_idle(random_left > 150);
            random_left--;
        end
        start = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
